### rtl/b3lm_pkg.sv
// Shared constants, codes and types for the binary 3x3 table morphology block.
package b3lm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int LINE_IDX_W = $clog2(MAX_WIDTH);

    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int HEIGHT_MAX = (1 << HEIGHT_W) - 1;
    localparam int ROW_W      = HEIGHT_W + 1;
    localparam int CNT_W      = $clog2(MAX_WIDTH * HEIGHT_MAX + 1);

    localparam int LUT_DEPTH  = 512;
    localparam int LUT_AW     = $clog2(LUT_DEPTH);
    localparam int WIN_W      = 9;

    localparam logic [7:0] PIX_THRESH = 8'd128;
    localparam logic [7:0] PIX_ON     = 8'd255;
    localparam logic [7:0] PIX_OFF    = 8'd0;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_PIXEL = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_PROC_Z  = 2'd2,
        CFG_UNUSED  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic shift;
        logic insert;
    } cell_ctrl_t;

endpackage

### rtl/b3lm_cell.sv
// One stage of the line store: holds a column's two-row history bit pair.
module b3lm_cell
    import b3lm_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic [1:0] prev_data,
    input  logic [1:0] new_data,
    output logic [1:0] data
);

    logic [1:0] data_reg;
    logic [1:0] data_next;

    always_comb
    begin
        data_next = ctrl.insert ? new_data : prev_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

### rtl/b3lm_line.sv
// Row-length delay line built from a chain of cells with a movable entry point.
module b3lm_line
    import b3lm_pkg::*;
(
    input  logic                  clk,
    input  logic                  shift,
    input  logic [LINE_IDX_W-1:0] ins_pt,
    input  logic [1:0]            new_data,
    output logic [1:0]            tap
);

    cell_ctrl_t ctrl [MAX_WIDTH];
    logic [1:0] data [MAX_WIDTH];

    genvar i;
    generate
        for (i = 0; i < MAX_WIDTH; i++)
        begin : g_cell
            logic [1:0] prev;

            assign ctrl[i].shift  = shift;
            assign ctrl[i].insert = (ins_pt == LINE_IDX_W'(i));

            if (i == 0)
            begin : g_first
                assign prev = new_data;
            end
            else
            begin : g_rest
                assign prev = data[i-1];
            end

            b3lm_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[i]),
                .prev_data (prev),
                .new_data  (new_data),
                .data      (data[i])
            );
        end
    endgenerate

    assign tap = data[MAX_WIDTH-1];

endmodule

### rtl/b3lm_lut.sv
// Neighbourhood lookup table: one write port, one registered read port.
module b3lm_lut
    import b3lm_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [LUT_AW-1:0] waddr,
    input  logic              wdata,
    input  logic              re,
    input  logic [LUT_AW-1:0] raddr,
    output logic              rdata
);

    logic mem [LUT_DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/binary_3x3_lut_morphology_core.sv
// Top level: binary 3x3 neighbourhood table lookup on a raster pixel stream.
// Throughput: one transaction per unstalled clock; every item type is taken back to back.
// Path: the item that completes a window is looked up into the table read register, then
// the output register; the window closes one row plus one pixel after its centre pixel.
// Reset clears counters, window, sticky flag and pipeline valids, not table or line;
// line data is rewritten before use; the user must load the table first, unchecked.
module binary_3x3_lut_morphology_core
    import b3lm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [LUT_AW-1:0]     lut_address,
    input  logic                  lut_bit,
    input  logic [7:0]            pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_pixel,
    output logic                  changed,
    output logic                  frame_end
);

    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic                  pz_reg;
    logic [WIDTH_W-1:0]    eff_w;
    logic [HEIGHT_W-1:0]   eff_h;
    logic [WIDTH_W+HEIGHT_W-1:0] area;
    logic [CNT_W-1:0]      total_m1_reg;
    logic [LINE_IDX_W-1:0] ins_pt;

    logic [LINE_IDX_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [WIN_W-1:0]      win_reg, win_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  accept, drain, step, restart_cfg;
    logic                  newbit, above, mid, is_c0, emit, col_wrap, last;
    logic [2:0]            col3;
    logic [1:0]            tap;
    logic [WIN_W-1:0]      win_shift, eval;

    logic                  v1_reg, v1_next, p1_move, fill;
    logic                  p1_centre_reg, p1_use_reg, p1_last_reg;
    logic                  lut_rd, res_bit, res_chg;

    logic                  v2_reg, v2_next;
    logic [7:0]            out_pixel_reg;
    logic                  changed_reg, frame_end_reg, flag_reg;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WIDTH_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        eff_h  = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        area   = (WIDTH_W+HEIGHT_W)'(eff_w) * (WIDTH_W+HEIGHT_W)'(eff_h);
        ins_pt = LINE_IDX_W'(MAX_WIDTH - 32'(eff_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            pz_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_PROC_Z: pz_reg     <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        total_m1_reg <= CNT_W'(area - 1'b1);
    end

    assign accept      = in_valid && !in_stall;
    assign drain       = row_reg >= ROW_W'(eff_h);
    assign step        = accept && ((func_t'(func) == FUNC_PIXEL && !drain)
                                 || (func_t'(func) == FUNC_FLUSH && drain));
    assign restart_cfg = cfg_we && (cfg_idx_t'(cfg_index) == CFG_WIDTH
                                 || cfg_idx_t'(cfg_index) == CFG_HEIGHT);

    b3lm_line u_line (
        .clk      (clk),
        .shift    (step),
        .ins_pt   (ins_pt),
        .new_data ({mid, newbit}),
        .tap      (tap)
    );

    always_comb
    begin
        newbit    = !drain && (pixel >= PIX_THRESH);
        above     = (row_reg >= ROW_W'(2)) && tap[1];
        mid       = (row_reg >= ROW_W'(1)) && tap[0];
        col3      = {newbit, mid, above};
        is_c0     = (col_reg == '0);
        win_shift = {col3, win_reg[WIN_W-1:3]};
        eval      = is_c0 ? {3'b000, win_reg[WIN_W-1:3]} : win_shift;
        emit      = is_c0 ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
        col_wrap  = (WIDTH_W'(col_reg) + 1'b1) == eff_w;
        last      = emit && (cnt_reg == total_m1_reg);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (restart_cfg || (step && last))
        begin
            col_next = '0;
            row_next = '0;
            win_next = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            win_next = is_c0 ? {col3, 6'b000000} : win_shift;
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            if (emit)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= win_next;
            cnt_reg <= cnt_next;
        end
    end

    assign fill = step && emit;

    b3lm_lut u_lut (
        .clk   (clk),
        .we    (accept && func_t'(func) == FUNC_LOAD),
        .waddr (lut_address),
        .wdata (lut_bit),
        .re    (fill),
        .raddr (eval),
        .rdata (lut_rd)
    );

    assign p1_move  = v1_reg && (!v2_reg || !out_stall);
    assign in_stall = v1_reg && !p1_move;

    always_comb
    begin
        v1_next = v1_reg;
        if (fill)
        begin
            v1_next = 1'b1;
        end
        else if (p1_move)
        begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (p1_move)
        begin
            v2_next = 1'b1;
        end
        else if (v2_reg && !out_stall)
        begin
            v2_next = 1'b0;
        end
        res_bit = p1_use_reg && lut_rd;
        res_chg = flag_reg || (res_bit != p1_centre_reg);
    end

    always_ff @(posedge clk)
    begin
        if (fill)
        begin
            p1_centre_reg <= eval[4];
            p1_use_reg    <= eval[4] || pz_reg;
            p1_last_reg   <= last;
        end
        if (p1_move)
        begin
            out_pixel_reg <= res_bit ? PIX_ON : PIX_OFF;
            changed_reg   <= res_chg;
            frame_end_reg <= p1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            flag_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (p1_move)
            begin
                flag_reg <= p1_last_reg ? 1'b0 : res_chg;
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_pixel = out_pixel_reg;
    assign changed   = changed_reg;
    assign frame_end = frame_end_reg;

endmodule

### rtl/b3lm_checker.sv
// Port-level checks for the morphology core, bound to the top level.
module b3lm_checker
    import b3lm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_pixel,
    input  logic       changed,
    input  logic       frame_end
);

    a_pix_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_pixel == PIX_ON || out_pixel == PIX_OFF))
        else $error("output pixel neither black nor white");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel)
            && $stable(changed) && $stable(frame_end))
        else $error("stalled output transaction changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output appeared without an input transaction two cycles earlier");

endmodule

bind binary_3x3_lut_morphology_core b3lm_checker u_checker (.*);

### tb/sv/morph_out_checker.sv
// Checker for the 3x3 table morphology core: software mirror of the block and output compare.
`timescale 1ns / 100ps

module morph_out_checker
    import b3lm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [LUT_AW-1:0]     lut_address,
    input  logic                  lut_bit,
    input  logic [7:0]            pixel,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            out_pixel,
    input  logic                  changed,
    input  logic                  frame_end,
    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic [7:0] pix;
        logic       chg;
        logic       fend;
    } morph_out_t;

    morph_out_t           expected_pixels[$];
    logic                 lut_bits [LUT_DEPTH];
    logic                 line_up1 [MAX_WIDTH];
    logic                 line_up2 [MAX_WIDTH];
    logic [WIN_W-1:0]     win;
    int unsigned          col_pos;
    int unsigned          row_pos;
    int unsigned          out_seen;
    logic                 chg_sticky;
    logic [WIDTH_W-1:0]   cfg_w;
    logic [HEIGHT_W-1:0]  cfg_h;
    logic                 cfg_pz;
    int                   fail_count;

    initial
    begin
        fail_count = 0;
        mismatches = 0;
        pending    = 0;
    end

    task automatic clear_frame();
        win      = '0;
        col_pos  = 0;
        row_pos  = 0;
        out_seen = 0;
    endtask

    task automatic reset_mirror();
        foreach (line_up1[i])
        begin
            line_up1[i] = 1'b0;
            line_up2[i] = 1'b0;
        end
        foreach (lut_bits[i])
            lut_bits[i] = 1'b0;
        clear_frame();
        chg_sticky = 1'b0;
        cfg_w      = WIDTH_RESET;
        cfg_h      = HEIGHT_RESET;
        cfg_pz     = 1'b0;
        expected_pixels.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WIDTH:
            begin
                cfg_w = data[WIDTH_W-1:0];
                clear_frame();
            end
            CFG_HEIGHT:
            begin
                cfg_h = data[HEIGHT_W-1:0];
                clear_frame();
            end
            CFG_PROC_Z: cfg_pz = data[0];
            default: ;
        endcase
    endtask

    task automatic predict_morph_pixel(input logic [1:0] f, input logic [LUT_AW-1:0] a,
                                       input logic b, input logic [7:0] p);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic             drain;
        logic             newbit;
        logic             above;
        logic             mid;
        logic             centre;
        logic             lut_out;
        logic             emit;
        logic [2:0]       column_bits;
        logic [WIN_W-1:0] eval_idx;
        morph_out_t       res;

        w = (cfg_w == 0) ? 1 : ((cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w);
        h = (cfg_h == 0) ? 1 : cfg_h;
        drain = (row_pos >= h);

        if (f == FUNC_LOAD)
        begin
            lut_bits[a] = b;
            return;
        end
        if (f == FUNC_NONE || (f == FUNC_PIXEL && drain) || (f == FUNC_FLUSH && !drain))
            return;

        newbit = !drain && (p >= PIX_THRESH);
        c = col_pos;
        r = row_pos;
        if (c >= MAX_WIDTH)
            c = 0;
        above = (r >= 2) ? line_up2[c] : 1'b0;
        mid   = (r >= 1) ? line_up1[c] : 1'b0;
        column_bits = {newbit, mid, above};
        line_up2[c] = mid;
        line_up1[c] = newbit;

        if (c == 0)
        begin
            eval_idx = win >> 3;
            win      = {column_bits, 6'b0};
            emit     = (r >= 2);
        end
        else
        begin
            win      = {column_bits, win[WIN_W-1:3]};
            eval_idx = win;
            emit     = (r >= 1);
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;

        if (!emit)
            return;

        centre  = eval_idx[4];
        lut_out = (centre || cfg_pz) ? lut_bits[eval_idx] : 1'b0;
        if (lut_out != centre)
            chg_sticky = 1'b1;
        out_seen++;
        res.pix  = lut_out ? PIX_ON : PIX_OFF;
        res.chg  = chg_sticky;
        res.fend = (out_seen >= w * h);
        expected_pixels.push_back(res);
        if (res.fend)
        begin
            clear_frame();
            chg_sticky = 1'b0;
        end
    endtask

    task automatic check_output();
        morph_out_t want;

        if (expected_pixels.size() == 0)
        begin
            $error("output transaction with nothing expected: out_pixel %0d", out_pixel);
            fail_count++;
            return;
        end
        want = expected_pixels.pop_front();
        if (out_pixel !== want.pix)
        begin
            $error("out_pixel: expected %0d, got %0d", want.pix, out_pixel);
            fail_count++;
        end
        if (changed !== want.chg)
        begin
            $error("changed: expected %0b, got %0b", want.chg, changed);
            fail_count++;
        end
        if (frame_end !== want.fend)
        begin
            $error("frame_end: expected %0b, got %0b", want.fend, frame_end);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            reset_mirror();
        else
        begin
            if (cfg_we)
                write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                predict_morph_pixel(func, lut_address, lut_bit, pixel);
            if (out_valid && !out_stall)
                check_output();
        end
        mismatches <= fail_count;
        pending    <= expected_pixels.size();
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the 3x3 table morphology core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
    import b3lm_pkg::*;
();

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            func;
    logic [LUT_AW-1:0]     lut_address;
    logic                  lut_bit;
    logic [7:0]            pixel;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_pixel;
    logic                  changed;
    logic                  frame_end;
    int                    mismatches;
    int                    pending;

    logic                  squeeze_req;
    int                    burst_left;
    int                    noise_pct;
    int                    counted;
    int                    cur_w;
    int                    cur_h;

    binary_3x3_lut_morphology_core uut (.*);

    morph_out_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #24_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int eff_w(input int w);
        return (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    endfunction

    function automatic int eff_h(input int h);
        return (h < 1) ? 1 : h;
    endfunction

    function automatic logic [7:0] pick_pixel(input int density);
        if ($urandom_range(0, 99) < density)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send(input logic [1:0] f, input logic [LUT_AW-1:0] a, input logic b,
                        input logic [7:0] p);
        int gap;

        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        in_valid    <= 1'b1;
        func        <= f;
        lut_address <= a;
        lut_bit     <= b;
        pixel       <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input int pz);
        cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_PROC_Z, CFG_DATA_W'(pz));
        cur_w = w;
        cur_h = h;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_noise(input logic drain_phase);
        if ($urandom_range(0, 99) < noise_pct)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    send(FUNC_LOAD, LUT_AW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
                    counted++;
                end
                2: send(FUNC_NONE, LUT_AW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)));
                default: send(drain_phase ? FUNC_PIXEL : FUNC_FLUSH,
                              LUT_AW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_frame(input int density, input int cut);
        int w;
        int n;

        w = eff_w(cur_w);
        n = w * eff_h(cur_h);
        for (int i = 0; i < n; i++)
        begin
            if (i == cut)
                return;
            add_noise(1'b0);
            send(FUNC_PIXEL, LUT_AW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                 pick_pixel(density));
            counted++;
        end
        for (int i = 0; i <= w; i++)
        begin
            add_noise(1'b1);
            send(FUNC_FLUSH, LUT_AW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
            counted++;
        end
    endtask

    initial
    begin
        int   mode;
        int   left;
        logic squeeze_done;

        out_stall   <= 1'b0;
        mode         = 0;
        left         = 0;
        squeeze_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else
            begin
                if (left <= 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 200);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (left % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        int   w;
        int   h;
        int   frames;
        int   density;
        int   cut;
        logic restart_needed;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_WIDTH;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        func        <= FUNC_LOAD;
        lut_address <= '0;
        lut_bit     <= 1'b0;
        pixel       <= '0;
        squeeze_req <= 1'b0;
        burst_left     = 0;
        noise_pct      = 0;
        counted        = 0;
        cur_w          = 1024;
        cur_h          = 1024;
        restart_needed = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table so no read ever hits an unwritten entry
        for (int a = 0; a < LUT_DEPTH; a++)
            send(FUNC_LOAD, LUT_AW'(a), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        wait_idle();
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));

        configure(3, 2, 0);
        send(FUNC_LOAD, 9'd0, 1'b1, 8'd255);
        send(FUNC_LOAD, 9'd511, 1'b0, 8'd0);
        send(FUNC_NONE, 9'd511, 1'b1, 8'd255);
        send(FUNC_FLUSH, 9'd0, 1'b0, 8'd0);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd255);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd127);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd128);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd0);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd255);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd128);
        send(FUNC_LOAD, 9'd16, 1'b0, 8'd0);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd200);
        repeat (4) send(FUNC_FLUSH, 9'd0, 1'b0, 8'd0);
        send(FUNC_FLUSH, 9'd0, 1'b0, 8'd0);
        wait_idle();
        configure(1, 1, 1);
        send(FUNC_PIXEL, 9'd0, 1'b0, 8'd0);
        repeat (2) send(FUNC_FLUSH, 9'd0, 1'b0, 8'd0);
        wait_idle();

        noise_pct = 2;
        configure(0, 0, 1);
        run_frame(100, -1);
        run_frame(0, -1);
        wait_idle();
        configure(2, 3, 0);
        run_frame(60, -1);
        wait_idle();
        cfg_write(CFG_PROC_Z, CFG_DATA_W'(1));
        run_frame(40, -1);
        wait_idle();

        // hold the receiver off on a small frame so the block backs up
        squeeze_req <= 1'b1;
        configure(8, 4, 1);
        run_frame(50, -1);
        wait_idle();

        noise_pct = 8;
        counted   = 0;
        while (counted < 850)
        begin
            if (restart_needed || $urandom_range(0, 5) != 0)
            begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                if ($urandom_range(0, 19) == 0)
                    w = 0;
                if ($urandom_range(0, 19) == 0)
                    h = 0;
                configure(w, h, $urandom_range(0, 1));
            end
            else
                cfg_write(CFG_PROC_Z, CFG_DATA_W'($urandom_range(0, 1)));
            frames         = $urandom_range(1, 3);
            density        = $urandom_range(0, 100);
            restart_needed = 1'b0;
            for (int f = 0; f < frames; f++)
            begin
                cut = -1;
                if (f == frames - 1 && $urandom_range(0, 7) == 0)
                begin
                    cut = $urandom_range(0, eff_w(cur_w) * eff_h(cur_h) - 1);
                    restart_needed = 1'b1;
                end
                run_frame(density, cut);
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
rtl/b3lm_pkg.sv
rtl/b3lm_cell.sv
rtl/b3lm_line.sv
rtl/b3lm_lut.sv
rtl/binary_3x3_lut_morphology_core.sv
rtl/b3lm_checker.sv
tb/sv/morph_out_checker.sv
tb/sv/tb_top.sv
